FILE: rtl/sah_pkg.sv
// ----------------------------------------------------------------------------
// sah_pkg
// Shared types and constants of the slot allocator: item and result
// payloads, status and action codes, register indexes and reset values,
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package sah_pkg;

    // Field widths
    localparam int SLOT_W     = 9;
    localparam int TIME_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_REUSED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADFREE = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SLOT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EARLY_GRACE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF     = 2'd2;

    // Register reset values
    localparam int                FIRST_SLOT_RST  = 33;
    localparam logic [TIME_W-1:0] EARLY_GRACE_RST = 32'd2000;
    localparam logic [TIME_W-1:0] HOLDOFF_RST     = 32'd500;

    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] slot_index;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   granted_slot;
        logic [STATUS_W-1:0] status;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;     // clear one free mark
        logic load;      // capture the input item
        logic do_free;   // perform a free
        logic scan;      // step the allocation scan
        logic take_hit;  // grant the slot found by the scan
        logic take_new;  // grant a fresh slot, or the last slot when full
    } sah_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;  // clearing pass at its last slot
        logic in_free;     // offered item is a free
        logic hit;         // scan found a reusable slot
        logic drained;     // scan ran out of slots
    } sah_stat_t;

endpackage

FILE: rtl/sah_ctrl.sv
// ----------------------------------------------------------------------------
// sah_ctrl
// Controller of the slot allocator: clearing pass after reset, item
// dispatch, free and scan sequencing.
// ----------------------------------------------------------------------------
module sah_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  sah_pkg::sah_stat_t  stat,
    output sah_pkg::sah_cmd_t   cmd,
    output logic                busy
);
    import sah_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_FREE  = 4'b0100,
        S_SCAN  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequence commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.in_free ? S_FREE : S_SCAN;
                end
            end
            S_FREE:
            begin
                cmd.do_free = 1'b1;
                state_next  = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (stat.drained)
                begin
                    cmd.take_new = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: rtl/sah_datapath.sv
// ----------------------------------------------------------------------------
// sah_datapath
// Datapath of the slot allocator: configuration registers, free mark and
// stamp memories, scan pointer with a two-stage eligibility pipeline,
// high-water mark and the result register.
// ----------------------------------------------------------------------------
module sah_datapath #(
    parameter int NUM_SLOTS = 512
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sah_pkg::sah_cmd_t               cmd,
    output sah_pkg::sah_stat_t              stat,
    input  sah_pkg::item_t                  item,
    input  logic                            cfg_we,
    input  logic [sah_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sah_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            done,
    output sah_pkg::result_t                result
);
    import sah_pkg::*;

    localparam int IW       = $clog2(NUM_SLOTS);
    localparam int CW       = $clog2(NUM_SLOTS + 1);
    localparam int W        = (CW > SLOT_W) ? CW : SLOT_W;
    localparam int HW_RESET = (FIRST_SLOT_RST < NUM_SLOTS) ? FIRST_SLOT_RST : NUM_SLOTS;

    // Configuration
    logic [SLOT_W-1:0] first_slot_reg;
    logic [TIME_W-1:0] early_grace_reg;
    logic [TIME_W-1:0] holdoff_reg;

    // Allocation state and captured item
    logic [CW-1:0]     hw_reg;
    logic [CW-1:0]     hw_next;
    logic [IW-1:0]     clr_reg;
    logic [W-1:0]      scan_addr_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [TIME_W-1:0] now_reg;

    // Memories and registered read data
    logic              mark_mem [NUM_SLOTS];
    logic [TIME_W-1:0] stamp_mem [NUM_SLOTS];
    logic              mark_rd_reg;
    logic [TIME_W-1:0] stamp_rd_reg;

    // Eligibility pipeline
    logic              p0_valid_reg;
    logic [W-1:0]      p0_idx_reg;
    logic              p1_valid_reg;
    logic [W-1:0]      p1_idx_reg;
    logic              p1_mark_reg;
    logic              p1_early_reg;
    logic              p1_fwd_reg;
    logic [TIME_W-1:0] p1_diff_reg;

    // Result
    logic              done_reg;
    logic              done_next;
    result_t           res_reg;
    result_t           res_next;

    logic [W-1:0]      hw_ext;
    logic [W-1:0]      first_ext;
    logic [W-1:0]      idx_ext;
    logic [W-1:0]      cand;
    logic [W-1:0]      new_slot;
    logic              full;
    logic              bad_free;
    logic              more;
    logic              issue;
    logic              flush;
    logic              p1_hit;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic              wr_mark;
    logic              stamp_we;
    logic [IW-1:0]     rd_addr;

    assign hw_ext    = W'(hw_reg);
    assign first_ext = W'(first_slot_reg);
    assign idx_ext   = W'(idx_reg);

    // Scan control
    assign more  = (scan_addr_reg < hw_ext);
    assign issue = cmd.scan && more;
    assign flush = cmd.load | cmd.take_hit | cmd.take_new;
    assign rd_addr = scan_addr_reg[IW-1:0];

    // Reuse test on the slot in the last stage
    assign p1_hit = p1_valid_reg && p1_mark_reg
                  && (p1_early_reg || (p1_fwd_reg && (p1_diff_reg > holdoff_reg)));

    // Fresh slot at the higher of mark and first_slot, or the last slot when full
    assign cand     = (first_ext > hw_ext) ? first_ext : hw_ext;
    assign full     = (cand >= W'(NUM_SLOTS));
    assign new_slot = full ? W'(NUM_SLOTS - 1) : cand;
    assign hw_next  = full ? hw_reg : CW'(cand + W'(1));

    // Slots at or above the mark cannot be freed
    assign bad_free = (idx_ext >= hw_ext);

    // Report status
    always_comb
    begin
        stat.clear_last = (clr_reg == IW'(NUM_SLOTS - 1));
        stat.in_free    = (item.action == ACT_FREE);
        stat.hit        = p1_hit;
        stat.drained    = !more && !p0_valid_reg && !p1_valid_reg;
    end

    // Select the mark write
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = clr_reg;
        wr_mark  = 1'b0;
        stamp_we = 1'b0;
        if (cmd.clear)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.do_free && !bad_free)
        begin
            wr_en    = 1'b1;
            wr_addr  = idx_ext[IW-1:0];
            wr_mark  = 1'b1;
            stamp_we = 1'b1;
        end
        else if (cmd.take_hit)
        begin
            wr_en   = 1'b1;
            wr_addr = p1_idx_reg[IW-1:0];
        end
        else if (cmd.take_new)
        begin
            wr_en   = 1'b1;
            wr_addr = new_slot[IW-1:0];
        end
    end

    // Write and read the memories
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mark_mem[wr_addr] <= wr_mark;
        end
        if (stamp_we)
        begin
            stamp_mem[wr_addr] <= now_reg;
        end
        mark_rd_reg  <= mark_mem[rd_addr];
        stamp_rd_reg <= stamp_mem[rd_addr];
    end

    // Build the result
    always_comb
    begin
        done_next = cmd.do_free | cmd.take_hit | cmd.take_new;
        res_next  = res_reg;
        if (cmd.do_free)
        begin
            res_next.granted_slot = idx_reg;
            res_next.status       = bad_free ? ST_BADFREE : ST_FREED;
        end
        else if (cmd.take_hit)
        begin
            res_next.granted_slot = p1_idx_reg[SLOT_W-1:0];
            res_next.status       = ST_REUSED;
        end
        else if (cmd.take_new)
        begin
            res_next.granted_slot = new_slot[SLOT_W-1:0];
            res_next.status       = full ? ST_FULL : ST_NEW;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_slot_reg  <= SLOT_W'(FIRST_SLOT_RST);
            early_grace_reg <= EARLY_GRACE_RST;
            holdoff_reg     <= HOLDOFF_RST;
            hw_reg          <= CW'(HW_RESET);
            clr_reg         <= '0;
            p0_valid_reg    <= 1'b0;
            p1_valid_reg    <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            // Take configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIRST_SLOT:  first_slot_reg  <= cfg_data[SLOT_W-1:0];
                    CFG_EARLY_GRACE: early_grace_reg <= cfg_data[TIME_W-1:0];
                    CFG_HOLDOFF:     holdoff_reg     <= cfg_data[TIME_W-1:0];
                    default:         ;
                endcase
            end
            // Advance the clearing pass
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + IW'(1);
            end
            // Raise the mark on a fresh grant
            if (cmd.take_new)
            begin
                hw_reg <= hw_next;
            end
            p0_valid_reg <= issue && !flush;
            p1_valid_reg <= p0_valid_reg && !flush;
            done_reg     <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        // Capture the item
        if (cmd.load)
        begin
            idx_reg <= item.slot_index;
            now_reg <= item.now_ms;
        end
        // Advance the scan pointer
        if (cmd.load)
        begin
            scan_addr_reg <= first_ext;
        end
        else if (issue)
        begin
            scan_addr_reg <= scan_addr_reg + W'(1);
        end
        p0_idx_reg   <= scan_addr_reg;
        p1_idx_reg   <= p0_idx_reg;
        p1_mark_reg  <= mark_rd_reg;
        p1_early_reg <= (stamp_rd_reg < early_grace_reg);
        p1_fwd_reg   <= (now_reg >= stamp_rd_reg);
        p1_diff_reg  <= now_reg - stamp_rd_reg;
        if (done_next)
        begin
            res_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

FILE: rtl/slot_allocator_with_reuse_holdoff.sv
// ----------------------------------------------------------------------------
// slot_allocator_with_reuse_holdoff
// Hands out slot numbers and holds freed slots back from reuse for a time.
//
// Usage: offer an item on item with start high; it is taken at an edge where
// busy is low. Each item gives one result on result, marked by done for one
// cycle; the receiver cannot stall it. Configuration is written through
// cfg_we / cfg_index / cfg_data while the block is idle.
// A free gives its result after the controller's free state. An allocation
// gives its result when the scan finds a reusable slot, or when the scan has
// drained with no slot qualifying; with first_slot at or above the mark no
// slot is scanned. Each scanned slot passes the registered memory read and
// the p1 stage before the reuse test.
// The scan reads one slot per cycle through the single read port of the free
// mark and stamp memories. busy drops in the cycle that done is shown, so the
// next item may be taken then. After reset a clearing pass zeroes all
// NUM_SLOTS free marks with busy held high; configuration writes are taken
// during it.
// ----------------------------------------------------------------------------
module slot_allocator_with_reuse_holdoff #(
    parameter int NUM_SLOTS = 512
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  sah_pkg::item_t                  item,
    output logic                            done,
    output sah_pkg::result_t                result,
    input  logic                            cfg_we,
    input  logic [sah_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sah_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sah_pkg::*;

    sah_cmd_t  cmd;
    sah_stat_t stat;

    // Sequence each item
    sah_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Hold slot state and compute results
    sah_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

endmodule

FILE: rtl/sah_checker.sv
// ----------------------------------------------------------------------------
// sah_checker
// Port-level checks of the slot allocator: result timing against busy,
// free latency and echo, legal status codes.
// ----------------------------------------------------------------------------
module sah_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  sah_pkg::item_t    item,
    input  logic              done,
    input  sah_pkg::result_t  result
);
    import sah_pkg::*;

    // A result ends a busy stretch and leaves the block ready
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("done without a preceding busy stretch");

    // An accepted item never sees a result in the next cycle
    a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result right after accepting an item");

    // A free is held busy in its free state and then finishes with done
    a_free_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.action == ACT_FREE)) |=> busy ##1 done)
        else $error("free did not finish in two cycles");

    // A free echoes its slot with a free status
    a_free_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.action == ACT_FREE)) |=> ##1
            ((result.granted_slot == $past(item.slot_index, 2))
             && ((result.status == ST_FREED) || (result.status == ST_BADFREE))))
        else $error("free result does not echo its slot");

    // Status is always a defined code
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status <= ST_BADFREE))
        else $error("undefined status code");

endmodule

bind slot_allocator_with_reuse_holdoff sah_checker u_sah_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);
